/* hw/rtl/gtm_pkg.sv */
// shared types, widths, register map and fixed-point helpers for the goertzel tone block
// no dependencies; the rtl files refer to it by scoped names, the sim files import it
package gtm_pkg;

	// widths of fields and state
	localparam int STATE_WIDTH = 48;
	localparam int SAMPLE_WIDTH = 16;
	localparam int COEFF_WIDTH = 16;
	localparam int LEN_WIDTH = 16;
	localparam int MAG_WIDTH = 16;
	localparam int HI_WIDTH = STATE_WIDTH - 32;
	localparam int PROD_WIDTH = STATE_WIDTH + COEFF_WIDTH;

	// magnitude datapath widths
	localparam int ABS_WIDTH = 31;
	localparam int SQ_WIDTH = 2 * ABS_WIDTH;
	localparam int ROOT_WIDTH = 32;
	localparam int RAD_WIDTH = 2 * ROOT_WIDTH;
	localparam int REM_WIDTH = ROOT_WIDTH + 2;
	localparam int NUM_WIDTH = ROOT_WIDTH + 3;
	localparam int DEN_WIDTH = LEN_WIDTH + 1;
	localparam int DREM_WIDTH = DEN_WIDTH + 1;
	localparam int SQRT_STEPS = ROOT_WIDTH;
	localparam int DIV_STEPS = NUM_WIDTH;
	localparam int STEP_WIDTH = $clog2(DIV_STEPS);

	// sample queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);

	// configuration port
	localparam int CFG_ADDR_WIDTH = 4;
	localparam int CFG_DATA_WIDTH = 32;
	localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0;
	localparam logic [1:0] REG_TWO_COS = 2'd1;
	localparam logic [1:0] REG_COSINE = 2'd2;
	localparam logic [1:0] REG_SINE = 2'd3;
	localparam logic [LEN_WIDTH-1:0] BLOCK_LENGTH_RST = 16'd205;
	localparam logic [COEFF_WIDTH-1:0] TWO_COS_RST = 16'h0000;
	localparam logic [COEFF_WIDTH-1:0] COSINE_RST = 16'h7fff;
	localparam logic [COEFF_WIDTH-1:0] SINE_RST = 16'h0000;

	// fractional bits of the coefficients
	localparam int TWO_COS_SHIFT = 14;
	localparam int TRIG_SHIFT = 15;

	typedef logic signed [STATE_WIDTH-1:0] state_t;
	typedef logic signed [STATE_WIDTH:0] wide_t;

	localparam state_t STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
	localparam state_t STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

	// one queued sample and its end-of-block mark
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic last;
	} q_entry_t;

	// state pair handed over at the end of a block
	typedef struct packed {
		state_t s1;
		state_t s2;
	} mag_job_t;

	// split sign-magnitude product, high and low partial products
	typedef struct packed {
		logic [HI_WIDTH+COEFF_WIDTH-1:0] hi;
		logic [32+COEFF_WIDTH-1:0] lo;
		logic neg;
	} prod_t;

	// partial products of |a| * |b|
	function automatic prod_t split_mul(state_t a, logic signed [COEFF_WIDTH-1:0] b);
		logic [STATE_WIDTH-1:0] ua;
		logic [COEFF_WIDTH-1:0] ub;
		prod_t p;
		ua = a[STATE_WIDTH-1] ? STATE_WIDTH'(-a) : STATE_WIDTH'(a);
		ub = b[COEFF_WIDTH-1] ? COEFF_WIDTH'(-b) : COEFF_WIDTH'(b);
		p.hi = (HI_WIDTH+COEFF_WIDTH)'(ua[STATE_WIDTH-1:32])
			* (HI_WIDTH+COEFF_WIDTH)'(ub);
		p.lo = (32+COEFF_WIDTH)'(ua[31:0]) * (32+COEFF_WIDTH)'(ub);
		p.neg = a[STATE_WIDTH-1] ^ b[COEFF_WIDTH-1];
		return p;
	endfunction

	// round half away from zero, drop sh fraction bits, saturate to the state range
	function automatic state_t round_sat(prod_t p, int sh);
		logic [PROD_WIDTH:0] sum;
		logic [PROD_WIDTH:0] m;
		logic [PROD_WIDTH:0] cap_pos;
		logic [PROD_WIDTH:0] cap_neg;
		state_t r;
		cap_neg = (PROD_WIDTH+1)'(1) << (STATE_WIDTH - 1);
		cap_pos = cap_neg - (PROD_WIDTH+1)'(1);
		sum = {1'b0, p.hi, 32'd0} + (PROD_WIDTH+1)'(p.lo)
			+ ((PROD_WIDTH+1)'(1) << (sh - 1));
		m = sum >> sh;
		if (!p.neg) begin
			r = (m > cap_pos) ? STATE_MAX : m[STATE_WIDTH-1:0];
		end else begin
			if (m > cap_neg) begin
				m = cap_neg;
			end
			r = ~m[STATE_WIDTH-1:0] + 1'b1;
		end
		return r;
	endfunction

	// clamp a one-bit-grown value back to the state range
	function automatic state_t clamp(wide_t v);
		state_t r;
		if (v > wide_t'(STATE_MAX)) begin
			r = STATE_MAX;
		end else if (v < wide_t'(STATE_MIN)) begin
			r = STATE_MIN;
		end else begin
			r = v[STATE_WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic state_t sat_sub(state_t a, state_t b);
		return clamp(wide_t'(a) - wide_t'(b));
	endfunction

endpackage

/* hw/rtl/goertzel_tone_magnitude_top.sv */
// goertzel single-bin tone magnitude: each sample passes the recurrence loop of multiply,
// round and add before the next enters; the 4-entry queue absorbs bursts
// block-end result runs mul, round, abs, square, sum, 32 root steps, prep and
// 35 divide steps, or goes from abs to done when the parts overflow; it overlaps the next block
// asynchronous active-low reset sets registers to their defaults and the state to zero
// top level: config registers, output register; depends on gtm_pkg and the gtm_ modules
module goertzel_tone_magnitude_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] magnitude
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [gtm_pkg::CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [gtm_pkg::CFG_DATA_WIDTH-1:0] pwdata,
	output logic [gtm_pkg::CFG_DATA_WIDTH-1:0] prdata,
	output logic pready
);

	logic [gtm_pkg::LEN_WIDTH-1:0] block_length_q;
	logic signed [gtm_pkg::COEFF_WIDTH-1:0] two_cos_q;
	logic signed [gtm_pkg::COEFF_WIDTH-1:0] cosine_q;
	logic signed [gtm_pkg::COEFF_WIDTH-1:0] sine_q;
	logic [1:0] reg_sel;
	logic cfg_write;

	logic q_push;
	logic q_ready;
	gtm_pkg::q_entry_t push_entry;
	gtm_pkg::q_entry_t pop_entry;
	logic q_valid;
	logic q_pop;
	logic mag_start;
	logic mag_ready;
	gtm_pkg::mag_job_t mag_job;
	logic res_valid;
	logic res_ready;
	logic [gtm_pkg::MAG_WIDTH-1:0] res_mag;

	logic out_valid_q;
	logic [gtm_pkg::MAG_WIDTH-1:0] out_data_q;

	// register file
	assign pready = 1'b1;
	assign reg_sel = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= gtm_pkg::BLOCK_LENGTH_RST;
			two_cos_q <= gtm_pkg::TWO_COS_RST;
			cosine_q <= gtm_pkg::COSINE_RST;
			sine_q <= gtm_pkg::SINE_RST;
		end else if (cfg_write) begin
			case (reg_sel)
				gtm_pkg::REG_BLOCK_LENGTH: block_length_q <= pwdata[15:0];
				gtm_pkg::REG_TWO_COS: two_cos_q <= pwdata[15:0];
				gtm_pkg::REG_COSINE: cosine_q <= pwdata[15:0];
				gtm_pkg::REG_SINE: sine_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_sel)
			gtm_pkg::REG_BLOCK_LENGTH: prdata = gtm_pkg::CFG_DATA_WIDTH'(block_length_q);
			gtm_pkg::REG_TWO_COS: prdata = gtm_pkg::CFG_DATA_WIDTH'(unsigned'(two_cos_q));
			gtm_pkg::REG_COSINE: prdata = gtm_pkg::CFG_DATA_WIDTH'(unsigned'(cosine_q));
			gtm_pkg::REG_SINE: prdata = gtm_pkg::CFG_DATA_WIDTH'(unsigned'(sine_q));
			default: prdata = '0;
		endcase
	end

	gtm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_valid(s_axis_tvalid),
		.s_ready(s_axis_tready),
		.s_sample(s_axis_tdata),
		.block_length(block_length_q),
		.q_ready(q_ready),
		.q_push(q_push),
		.q_entry(push_entry)
	);

	gtm_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_entry(push_entry),
		.push_ready(q_ready),
		.pop(q_pop),
		.pop_entry(pop_entry),
		.pop_valid(q_valid)
	);

	gtm_recur u_recur (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_entry(pop_entry),
		.q_pop(q_pop),
		.two_cos(two_cos_q),
		.mag_ready(mag_ready),
		.mag_start(mag_start),
		.mag_job(mag_job)
	);

	gtm_mag u_mag (
		.clk(clk),
		.arst_n(arst_n),
		.start(mag_start),
		.job(mag_job),
		.ready(mag_ready),
		.cosine(cosine_q),
		.sine(sine_q),
		.block_length(block_length_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_mag(res_mag)
	);

	// output register
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_mag;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule

/* hw/rtl/gtm_front.sv */
// front end: takes samples from the input stream, counts them and marks block ends
// depends on gtm_pkg
module gtm_front (
	input  logic clk,
	input  logic arst_n,
	input  logic s_valid,
	output logic s_ready,
	input  logic signed [gtm_pkg::SAMPLE_WIDTH-1:0] s_sample,
	input  logic [gtm_pkg::LEN_WIDTH-1:0] block_length,
	input  logic q_ready,
	output logic q_push,
	output gtm_pkg::q_entry_t q_entry
);

	logic [gtm_pkg::LEN_WIDTH-1:0] count_q;
	logic [gtm_pkg::LEN_WIDTH-1:0] len_eff;
	logic is_last;

	// a zero length behaves as one sample per block
	assign len_eff = (block_length == '0) ? gtm_pkg::LEN_WIDTH'(1) : block_length;
	assign is_last = ({1'b0, count_q} + (gtm_pkg::LEN_WIDTH+1)'(1)) >= {1'b0, len_eff};

	assign s_ready = q_ready;
	assign q_push = s_valid && q_ready;
	assign q_entry.sample = s_sample;
	assign q_entry.last = is_last;

	// sample counter within the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push) begin
			count_q <= is_last ? '0 : count_q + 1'b1;
		end
	end

endmodule

/* hw/rtl/gtm_fifo.sv */
// short queue of classified samples between the front end and the recurrence
// depends on gtm_pkg
module gtm_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  gtm_pkg::q_entry_t push_entry,
	output logic push_ready,
	input  logic pop,
	output gtm_pkg::q_entry_t pop_entry,
	output logic pop_valid
);

	gtm_pkg::q_entry_t mem_q [gtm_pkg::QUEUE_DEPTH];
	logic [gtm_pkg::QPTR_WIDTH-1:0] wr_ptr_q;
	logic [gtm_pkg::QPTR_WIDTH-1:0] rd_ptr_q;
	logic [gtm_pkg::QPTR_WIDTH:0] fill_q;

	assign push_ready = fill_q != (gtm_pkg::QPTR_WIDTH+1)'(gtm_pkg::QUEUE_DEPTH);
	assign pop_valid = fill_q != '0;
	assign pop_entry = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

/* hw/rtl/gtm_recur.sv */
// back end: goertzel recurrence s = two_cos*s1 - s2 + x, one sample at a time
// depends on gtm_pkg; hands the final state pair to the magnitude unit
module gtm_recur (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  gtm_pkg::q_entry_t q_entry,
	output logic q_pop,
	input  logic signed [gtm_pkg::COEFF_WIDTH-1:0] two_cos,
	input  logic mag_ready,
	output logic mag_start,
	output gtm_pkg::mag_job_t mag_job
);

	localparam logic [1:0] R_IDLE = 2'd0;
	localparam logic [1:0] R_MUL = 2'd1;
	localparam logic [1:0] R_RND = 2'd2;
	localparam logic [1:0] R_ADD = 2'd3;

	logic [1:0] state_q;
	gtm_pkg::state_t s1_q;
	gtm_pkg::state_t s2_q;
	gtm_pkg::state_t t_q;
	gtm_pkg::prod_t prod_q;
	logic signed [gtm_pkg::SAMPLE_WIDTH-1:0] x_q;
	logic last_q;
	gtm_pkg::state_t diff;
	gtm_pkg::state_t s_new;
	logic add_done;

	// new state value
	assign diff = gtm_pkg::sat_sub(t_q, s2_q);
	assign s_new = gtm_pkg::clamp(gtm_pkg::wide_t'(diff) + gtm_pkg::wide_t'(x_q));

	// a block end waits for the magnitude unit to take the state pair
	assign add_done = !last_q || mag_ready;
	assign q_pop = q_valid && ((state_q == R_IDLE) || ((state_q == R_ADD) && add_done));
	assign mag_start = (state_q == R_ADD) && last_q && mag_ready;
	assign mag_job.s1 = s_new;
	assign mag_job.s2 = s1_q;

	// sequencer and recurrence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			s1_q <= '0;
			s2_q <= '0;
		end else begin
			case (state_q)
				R_IDLE: begin
					if (q_valid) begin
						state_q <= R_MUL;
					end
				end
				R_MUL: begin
					state_q <= R_RND;
				end
				R_RND: begin
					state_q <= R_ADD;
				end
				R_ADD: begin
					if (add_done) begin
						if (last_q) begin
							s1_q <= '0;
							s2_q <= '0;
						end else begin
							s1_q <= s_new;
							s2_q <= s1_q;
						end
						state_q <= q_valid ? R_MUL : R_IDLE;
					end
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			x_q <= q_entry.sample;
			last_q <= q_entry.last;
		end
		if (state_q == R_MUL) begin
			prod_q <= gtm_pkg::split_mul(s1_q, two_cos);
		end
		if (state_q == R_RND) begin
			t_q <= gtm_pkg::round_sat(prod_q, gtm_pkg::TWO_COS_SHIFT);
		end
	end

endmodule

/* hw/rtl/gtm_mag.sv */
// back end: block-end magnitude, serial square root and serial divide by n/2
// depends on gtm_pkg; runs while the recurrence works on the next block
module gtm_mag (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  gtm_pkg::mag_job_t job,
	output logic ready,
	input  logic signed [gtm_pkg::COEFF_WIDTH-1:0] cosine,
	input  logic signed [gtm_pkg::COEFF_WIDTH-1:0] sine,
	input  logic [gtm_pkg::LEN_WIDTH-1:0] block_length,
	output logic res_valid,
	input  logic res_ready,
	output logic [gtm_pkg::MAG_WIDTH-1:0] res_mag
);

	localparam logic [3:0] M_IDLE = 4'd0;
	localparam logic [3:0] M_MUL = 4'd1;
	localparam logic [3:0] M_RND = 4'd2;
	localparam logic [3:0] M_ABS = 4'd3;
	localparam logic [3:0] M_SQ = 4'd4;
	localparam logic [3:0] M_SUM = 4'd5;
	localparam logic [3:0] M_SQRT = 4'd6;
	localparam logic [3:0] M_PREP = 4'd7;
	localparam logic [3:0] M_DIV = 4'd8;
	localparam logic [3:0] M_DONE = 4'd9;
	localparam logic [gtm_pkg::STEP_WIDTH-1:0] SQRT_LAST =
		gtm_pkg::STEP_WIDTH'(gtm_pkg::SQRT_STEPS - 1);
	localparam logic [gtm_pkg::STEP_WIDTH-1:0] DIV_LAST =
		gtm_pkg::STEP_WIDTH'(gtm_pkg::DIV_STEPS - 1);

	logic [3:0] state_q;
	logic [gtm_pkg::STEP_WIDTH-1:0] step_q;

	gtm_pkg::state_t s1_q;
	gtm_pkg::state_t s2_q;
	gtm_pkg::prod_t pc_q;
	gtm_pkg::prod_t ps_q;
	gtm_pkg::state_t pcr_q;
	gtm_pkg::state_t im_q;
	logic [gtm_pkg::ABS_WIDTH-1:0] ur_q;
	logic [gtm_pkg::ABS_WIDTH-1:0] ui_q;
	logic [gtm_pkg::SQ_WIDTH-1:0] sqr_q;
	logic [gtm_pkg::SQ_WIDTH-1:0] sqi_q;
	logic [gtm_pkg::RAD_WIDTH-1:0] rad_q;
	logic [gtm_pkg::ROOT_WIDTH-1:0] root_q;
	logic [gtm_pkg::REM_WIDTH-1:0] rem_q;
	logic [gtm_pkg::NUM_WIDTH-1:0] num_q;
	logic [gtm_pkg::NUM_WIDTH-1:0] quo_q;
	logic [gtm_pkg::DEN_WIDTH-1:0] den_q;
	logic [gtm_pkg::DREM_WIDTH-1:0] drem_q;
	logic [gtm_pkg::MAG_WIDTH-1:0] mag_q;

	gtm_pkg::state_t re;
	logic [gtm_pkg::STATE_WIDTH-1:0] ure;
	logic [gtm_pkg::STATE_WIDTH-1:0] uim;
	logic ovf;
	logic [gtm_pkg::REM_WIDTH-1:0] rem_in;
	logic [gtm_pkg::REM_WIDTH-1:0] trial;
	logic [gtm_pkg::DREM_WIDTH-1:0] drem_in;
	logic div_bit;
	logic [gtm_pkg::NUM_WIDTH-1:0] quo_next;
	logic [gtm_pkg::LEN_WIDTH-1:0] len_eff;

	assign ready = state_q == M_IDLE;
	assign res_valid = state_q == M_DONE;
	assign res_mag = mag_q;

	// real and imaginary parts, overflow when either reaches 2^31
	assign re = gtm_pkg::sat_sub(s1_q, pcr_q);
	assign ure = re[gtm_pkg::STATE_WIDTH-1] ? gtm_pkg::STATE_WIDTH'(-re)
		: gtm_pkg::STATE_WIDTH'(re);
	assign uim = im_q[gtm_pkg::STATE_WIDTH-1] ? gtm_pkg::STATE_WIDTH'(-im_q)
		: gtm_pkg::STATE_WIDTH'(im_q);
	assign ovf = (ure[gtm_pkg::STATE_WIDTH-1:gtm_pkg::ABS_WIDTH] != '0)
		|| (uim[gtm_pkg::STATE_WIDTH-1:gtm_pkg::ABS_WIDTH] != '0);

	// one root digit per cycle
	assign rem_in = {rem_q[gtm_pkg::REM_WIDTH-3:0], rad_q[gtm_pkg::RAD_WIDTH-1 -: 2]};
	assign trial = {root_q, 2'b01};

	// one quotient bit per cycle
	assign drem_in = {drem_q[gtm_pkg::DREM_WIDTH-2:0], num_q[gtm_pkg::NUM_WIDTH-1]};
	assign div_bit = drem_in >= {1'b0, den_q};
	assign quo_next = {quo_q[gtm_pkg::NUM_WIDTH-2:0], div_bit};

	assign len_eff = (block_length == '0) ? gtm_pkg::LEN_WIDTH'(1) : block_length;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			step_q <= '0;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					state_q <= M_RND;
				end
				M_RND: begin
					state_q <= M_ABS;
				end
				M_ABS: begin
					state_q <= ovf ? M_DONE : M_SQ;
				end
				M_SQ: begin
					state_q <= M_SUM;
				end
				M_SUM: begin
					step_q <= '0;
					state_q <= M_SQRT;
				end
				M_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == SQRT_LAST) begin
						state_q <= M_PREP;
					end
				end
				M_PREP: begin
					step_q <= '0;
					state_q <= M_DIV;
				end
				M_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == DIV_LAST) begin
						state_q <= M_DONE;
					end
				end
				M_DONE: begin
					if (res_ready) begin
						state_q <= M_IDLE;
					end
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (start) begin
					s1_q <= job.s1;
					s2_q <= job.s2;
				end
			end
			M_MUL: begin
				pc_q <= gtm_pkg::split_mul(s2_q, cosine);
				ps_q <= gtm_pkg::split_mul(s2_q, sine);
			end
			M_RND: begin
				pcr_q <= gtm_pkg::round_sat(pc_q, gtm_pkg::TRIG_SHIFT);
				im_q <= gtm_pkg::round_sat(ps_q, gtm_pkg::TRIG_SHIFT);
			end
			M_ABS: begin
				ur_q <= ure[gtm_pkg::ABS_WIDTH-1:0];
				ui_q <= uim[gtm_pkg::ABS_WIDTH-1:0];
				if (ovf) begin
					mag_q <= '1;
				end
			end
			M_SQ: begin
				sqr_q <= gtm_pkg::SQ_WIDTH'(ur_q) * gtm_pkg::SQ_WIDTH'(ur_q);
				sqi_q <= gtm_pkg::SQ_WIDTH'(ui_q) * gtm_pkg::SQ_WIDTH'(ui_q);
			end
			M_SUM: begin
				rad_q <= gtm_pkg::RAD_WIDTH'(sqr_q) + gtm_pkg::RAD_WIDTH'(sqi_q);
				root_q <= '0;
				rem_q <= '0;
			end
			M_SQRT: begin
				rad_q <= rad_q << 2;
				if (rem_in >= trial) begin
					rem_q <= rem_in - trial;
					root_q <= {root_q[gtm_pkg::ROOT_WIDTH-2:0], 1'b1};
				end else begin
					rem_q <= rem_in;
					root_q <= {root_q[gtm_pkg::ROOT_WIDTH-2:0], 1'b0};
				end
			end
			M_PREP: begin
				// (4*root + n) / (2*n) is 2*root/n rounded half up
				num_q <= gtm_pkg::NUM_WIDTH'({root_q, 2'b00})
					+ gtm_pkg::NUM_WIDTH'(len_eff);
				den_q <= {len_eff, 1'b0};
				drem_q <= '0;
				quo_q <= '0;
			end
			M_DIV: begin
				num_q <= num_q << 1;
				quo_q <= quo_next;
				drem_q <= div_bit ? (drem_in - {1'b0, den_q}) : drem_in;
				if (step_q == DIV_LAST) begin
					mag_q <= (quo_next[gtm_pkg::NUM_WIDTH-1:gtm_pkg::MAG_WIDTH] != '0)
						? '1 : quo_next[gtm_pkg::MAG_WIDTH-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* hw/rtl/gtm_checker.sv */
// port-level checks for the goertzel tone block, bound to the top level
// depends on gtm_pkg and goertzel_tone_magnitude_top
module gtm_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [gtm_pkg::CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [gtm_pkg::CFG_DATA_WIDTH-1:0] pwdata,
	input  logic [gtm_pkg::CFG_DATA_WIDTH-1:0] prdata,
	input  logic pready
);

	// a stalled result transaction holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// the config port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

	// a read right after a write to the same register returns the written value
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(psel && penable && pwrite) && psel && !pwrite && (paddr == $past(paddr))
		|-> prdata[15:0] == $past(pwdata[15:0]))
		else $error("register readback mismatch");

	// an accepted sample carries no unknown bits
	a_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> !$isunknown(s_axis_tdata))
		else $error("unknown sample accepted");

endmodule

bind goertzel_tone_magnitude_top gtm_checker u_gtm_checker (.*);

/* sim/tone_magnitude_checker.sv */
// checker for the goertzel tone block: follows the register writes, predicts each
// block-end magnitude from the accepted samples and compares it with the output stream
// depends on gtm_pkg for widths, register indexes and reset values
module tone_magnitude_checker
	import gtm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [15:0] m_tdata,   // [15:0] magnitude
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic pready,
	input  logic [CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [CFG_DATA_WIDTH-1:0] pwdata,
	output int failures,
	output int outstanding
);

	localparam logic [63:0] POS_CAP = (64'd1 << (STATE_WIDTH - 1)) - 64'd1;
	localparam logic [63:0] NEG_CAP = 64'd1 << (STATE_WIDTH - 1);
	localparam longint STATE_HI = longint'(POS_CAP);
	localparam longint STATE_LO = -longint'(NEG_CAP);
	localparam logic [63:0] PART_LIMIT = 64'd1 << 31;
	localparam logic [63:0] MAG_MAX = (64'd1 << MAG_WIDTH) - 64'd1;

	// shadow of the configuration registers
	logic [LEN_WIDTH-1:0] cfg_len;
	logic signed [COEFF_WIDTH-1:0] cfg_two_cos;
	logic signed [COEFF_WIDTH-1:0] cfg_cos;
	logic signed [COEFF_WIDTH-1:0] cfg_sin;

	// recurrence state: latest and previous accumulator, position in block
	longint acc_now;
	longint acc_prev;
	logic [LEN_WIDTH-1:0] samples_in_block;

	logic [MAG_WIDTH-1:0] magnitude_expected[$];
	logic [MAG_WIDTH-1:0] want_mag;
	logic [MAG_WIDTH-1:0] next_mag;
	bit closes_block;
	int fail_count;

	function automatic longint clamp_to_state(longint v);
		if (v > STATE_HI) return STATE_HI;
		if (v < STATE_LO) return STATE_LO;
		return v;
	endfunction

	// a * c / 2^frac, rounded half away from zero, saturated to the state range
	function automatic longint coeff_mul(longint a, logic signed [COEFF_WIDTH-1:0] c, int frac);
		logic [63:0] ua;
		logic [63:0] uc;
		logic [63:0] m;
		bit neg;
		ua = (a < 0) ? 64'(-a) : 64'(a);
		uc = (c < 0) ? 64'(-longint'(c)) : 64'(longint'(c));
		neg = (a < 0) != (c < 0);
		m = (ua * uc + (64'd1 << (frac - 1))) >> frac;
		if (!neg) begin
			return (m > POS_CAP) ? STATE_HI : longint'(m);
		end
		if (m > NEG_CAP) begin
			m = NEG_CAP;
		end
		return -longint'(m);
	endfunction

	// floor of the square root, digit by digit
	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] pw;
		res = '0;
		pw = 64'd1 << 62;
		while (pw > v) pw = pw >> 2;
		while (pw != 0) begin
			if (v >= res + pw) begin
				v = v - (res + pw);
				res = (res >> 1) + pw;
			end else begin
				res = res >> 1;
			end
			pw = pw >> 2;
		end
		return res;
	endfunction

	// bin magnitude from the current state pair, scaled by 2/N and saturated
	function automatic logic [MAG_WIDTH-1:0] block_magnitude(longint n);
		longint re;
		longint im;
		logic [63:0] ur;
		logic [63:0] ui;
		logic [63:0] root;
		logic [63:0] quot;
		re = clamp_to_state(acc_now - coeff_mul(acc_prev, cfg_cos, TRIG_SHIFT));
		im = coeff_mul(acc_prev, cfg_sin, TRIG_SHIFT);
		ur = (re < 0) ? 64'(-re) : 64'(re);
		ui = (im < 0) ? 64'(-im) : 64'(im);
		if (ur >= PART_LIMIT || ui >= PART_LIMIT) begin
			return MAG_MAX[MAG_WIDTH-1:0];
		end
		root = root_floor(ur * ur + ui * ui);
		quot = (64'd4 * root + 64'(n)) / (64'd2 * 64'(n));
		return (quot > MAG_MAX) ? MAG_MAX[MAG_WIDTH-1:0] : quot[MAG_WIDTH-1:0];
	endfunction

	// one recurrence step; closes the block when the count reaches the length
	task automatic take_sample(input logic signed [SAMPLE_WIDTH-1:0] x, output bit block_done,
			output logic [MAG_WIDTH-1:0] mag);
		longint prod;
		longint acc_new;
		longint n;
		logic [LEN_WIDTH:0] cnt;
		prod = coeff_mul(acc_now, cfg_two_cos, TWO_COS_SHIFT);
		acc_new = clamp_to_state(clamp_to_state(prod - acc_prev) + longint'(x));
		n = (cfg_len == 0) ? 1 : longint'(cfg_len);
		cnt = {1'b0, samples_in_block} + 1'b1;
		acc_prev = acc_now;
		acc_now = acc_new;
		block_done = longint'(cnt) >= n;
		mag = '0;
		if (block_done) begin
			mag = block_magnitude(n);
			acc_now = 0;
			acc_prev = 0;
			samples_in_block = '0;
		end else begin
			samples_in_block = cnt[LEN_WIDTH-1:0];
		end
	endtask

	task automatic flag_error(string msg);
		if (fail_count < 10) begin
			$display("%s", msg);
		end
		fail_count++;
	endtask

	// results are checked before the same edge's sample and register write take effect
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len = BLOCK_LENGTH_RST;
			cfg_two_cos = TWO_COS_RST;
			cfg_cos = COSINE_RST;
			cfg_sin = SINE_RST;
			acc_now = 0;
			acc_prev = 0;
			samples_in_block = '0;
			magnitude_expected.delete();
			fail_count = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			// output transaction against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (magnitude_expected.size() == 0) begin
					flag_error($sformatf("unexpected magnitude: expected none, got %0d", m_tdata));
				end else begin
					want_mag = magnitude_expected.pop_front();
					if (m_tdata !== want_mag) begin
						flag_error($sformatf("magnitude mismatch: expected %0d, got %0d",
							want_mag, m_tdata));
					end
				end
			end
			// input transaction
			if (s_tvalid && s_tready) begin
				take_sample($signed(s_tdata), closes_block, next_mag);
				if (closes_block) begin
					magnitude_expected = {magnitude_expected, next_mag};
				end
			end
			// register write
			if (psel && penable && pwrite && pready) begin
				case (paddr[CFG_ADDR_WIDTH-1:2])
					REG_BLOCK_LENGTH: cfg_len = pwdata[LEN_WIDTH-1:0];
					REG_TWO_COS: cfg_two_cos = pwdata[COEFF_WIDTH-1:0];
					REG_COSINE: cfg_cos = pwdata[COEFF_WIDTH-1:0];
					REG_SINE: cfg_sin = pwdata[COEFF_WIDTH-1:0];
					default: ;
				endcase
			end
			failures <= fail_count;
			outstanding <= magnitude_expected.size();
		end
	end

endmodule

/* sim/tb_top.sv */
// top of the goertzel tone testbench: clock, reset, register setup, sample stimulus,
// random output back-pressure, watchdog and verdict
// depends on gtm_pkg, goertzel_tone_magnitude_top and tone_magnitude_checker
module tb_top;
	import gtm_pkg::*;

	localparam real PI = 3.14159265359;
	localparam int SETTLE_CYCLES = 200;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef enum {SRC_TONE, SRC_ALTERNATE, SRC_NOISE} sample_src_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // [15:0] sample
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // [15:0] magnitude
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_WIDTH-1:0] paddr = '0;
	logic [CFG_DATA_WIDTH-1:0] pwdata = '0;
	logic [CFG_DATA_WIDTH-1:0] prdata;
	logic pready;

	int failures;
	int pending_results;
	int tx_idle_pct = 33;
	int rx_idle_pct = 33;
	int hold_asked = 0;
	int hold_given = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	goertzel_tone_magnitude_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	tone_magnitude_checker magnitude_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.s_tdata(s_axis_tdata),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.failures(failures),
		.outstanding(pending_results)
	);

	always #5 clk = ~clk;

	// output side: random stalls, plus a long hold-off whenever one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_given) begin
			m_axis_tready <= 1'b0;
			hold_given <= hold_given + 1;
			hold_left <= RX_HOLD_CYCLES;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable && pwrite && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// setup and access phase, then an idle phase with psel low
	task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [15:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// drain every predicted magnitude, then let queued samples run through
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// round to nearest and saturate to a signed 16-bit code
	function automatic logic [15:0] to_fixed(real v, real scale);
		real r;
		int q;
		r = v * scale;
		if (r >= 32767.0) return 16'h7fff;
		if (r <= -32768.0) return 16'h8000;
		q = (r >= 0.0) ? $rtoi(r + 0.5) : -$rtoi(0.5 - r);
		return 16'(q);
	endfunction

	function automatic logic [15:0] pick_coeff();
		case ($urandom_range(3))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	// coefficients for bin k of an n_len-point block
	task automatic tune_bin(input int n_len, input real bin);
		real w;
		w = 2.0 * PI * bin / n_len;
		write_register(REG_BLOCK_LENGTH, 16'(n_len));
		write_register(REG_TWO_COS, to_fixed(2.0 * $cos(w), 16384.0));
		write_register(REG_COSINE, to_fixed($cos(w), 32768.0));
		write_register(REG_SINE, to_fixed($sin(w), 32768.0));
	endtask

	// sinusoid with a little noise, now and then replaced by a random code
	function automatic logic [15:0] tone_sample(int i, real w, real amp, real phase_off);
		real noise;
		if ($urandom_range(9) == 0) return 16'($urandom);
		noise = $itor($urandom_range(400)) - 200.0;
		return to_fixed(amp * $sin(w * i + phase_off) + noise, 1.0);
	endfunction

	initial begin
		logic [15:0] extreme_samples[7];
		sample_src_t src;
		int len;
		int k;
		int n_items;
		int amp_i;
		int rx_pct;
		real w;
		real amp;
		real phase_off;
		logic [15:0] value;

		extreme_samples = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001,
			16'hffff, 16'h5555, 16'haaaa};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length acts as one: every sample closes a block, large ones saturate
		write_register(REG_BLOCK_LENGTH, 16'd0);
		write_register(REG_TWO_COS, 16'h8000);
		write_register(REG_COSINE, 16'h7fff);
		write_register(REG_SINE, 16'h8000);
		foreach (extreme_samples[i]) send_sample(extreme_samples[i]);
		settle();
		write_register(REG_BLOCK_LENGTH, 16'd1);
		write_register(REG_TWO_COS, 16'h7fff);
		write_register(REG_COSINE, 16'h8000);
		write_register(REG_SINE, 16'h7fff);
		send_sample(16'h8000);
		send_sample(16'h7fff);
		settle();
		write_register(REG_BLOCK_LENGTH, 16'd2);
		send_sample(16'h7fff);
		send_sample(16'h7fff);
		send_sample(16'h8000);
		send_sample(16'h8000);
		settle();
		// longest block, then the length is cut below the count mid-block
		write_register(REG_BLOCK_LENGTH, 16'hffff);
		for (int i = 0; i < 8; i++) send_sample(i[0] ? 16'h8000 : 16'h7fff);
		settle();
		write_register(REG_BLOCK_LENGTH, 16'd4);
		for (int i = 0; i < 5; i++) send_sample(16'($urandom));

		// random phases, each with its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			tx_idle_pct = 33;
			rx_pct = 33;
			src = SRC_TONE;
			phase_off = $itor($urandom_range(628)) / 100.0;
			amp = $itor($urandom_range(32767, 500));
			w = 0.0;
			case (ph)
				0: begin
					len = $urandom_range(64, 16);
					k = $urandom_range(len / 2);
					tune_bin(len, k);
					w = 2.0 * PI * k / len;
					n_items = len * 3;
				end
				1: begin
					// long stretch with no idling on either side
					len = 32;
					k = $urandom_range(16);
					tune_bin(len, k);
					w = 2.0 * PI * k / len;
					n_items = len * 3;
					tx_idle_pct = 0;
					rx_pct = 0;
				end
				2: begin
					// short blocks while the output is held off: the block backs up
					len = $urandom_range(8, 1);
					write_register(REG_BLOCK_LENGTH, 16'(len));
					write_register(REG_TWO_COS, pick_coeff());
					write_register(REG_COSINE, pick_coeff());
					write_register(REG_SINE, pick_coeff());
					n_items = len * 20;
					src = SRC_NOISE;
					tx_idle_pct = 0;
					hold_asked <= hold_asked + 1;
				end
				3: begin
					// double pole at -1 driven at its own rate: parts exceed 2^31
					len = 280;
					write_register(REG_BLOCK_LENGTH, 16'(len));
					write_register(REG_TWO_COS, 16'h8000);
					write_register(REG_COSINE, 16'h7fff);
					write_register(REG_SINE, pick_coeff());
					n_items = len;
					src = SRC_ALTERNATE;
				end
				4: begin
					len = $urandom_range(40);
					write_register(REG_BLOCK_LENGTH, 16'(len));
					write_register(REG_TWO_COS, pick_coeff());
					write_register(REG_COSINE, pick_coeff());
					write_register(REG_SINE, pick_coeff());
					n_items = 60;
					src = SRC_NOISE;
				end
				default: begin
					// tone halfway between two bins, ends mid-block
					len = $urandom_range(128, 64);
					k = $urandom_range(len / 2 - 1);
					tune_bin(len, k);
					w = 2.0 * PI * (k + 0.5) / len;
					n_items = len + len / 2;
				end
			endcase
			rx_idle_pct <= rx_pct;
			for (int i = 0; i < n_items; i++) begin
				case (src)
					SRC_TONE: value = tone_sample(i, w, amp, phase_off);
					SRC_ALTERNATE: begin
						amp_i = $urandom_range(32767, 28000);
						if (!i[0]) begin
							value = 16'(amp_i);
						end else if ($urandom_range(19) == 0) begin
							value = 16'h8000;
						end else begin
							value = 16'(-amp_i);
						end
					end
					default: value = 16'($urandom);
				endcase
				send_sample(value);
			end
		end

		settle();
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
